// ===== rtl/trae_pkg.sv =====
// Shared types, constants and helpers for the transport receiver ack engine.
`default_nettype none

package trae_pkg;

  localparam int NUM_FLOWS_DEF = 16;
  localparam int SEQ_SPACE_DEF = 1024;

  localparam int FLOW_W = 4;
  localparam int NODE_W = 8;
  localparam int SEQ_W  = 10;
  localparam int TIME_W = 32;
  localparam int ACKN_W = 11;
  localparam int SIZE_W = 16;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  // Configuration register map
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_HOST_ID      = 3'd0;
  localparam logic [2:0] REG_RESEND_DELAY = 3'd1;
  localparam logic [2:0] REG_SYN_BYTES    = 3'd2;
  localparam logic [2:0] REG_FIN_BYTES    = 3'd3;
  localparam logic [2:0] REG_ACK_BYTES    = 3'd4;

  localparam logic [7:0]  HOST_ID_RST      = 8'd0;
  localparam logic [15:0] RESEND_DELAY_RST = 16'd500;
  localparam logic [15:0] SYN_BYTES_RST    = 16'd64;
  localparam logic [15:0] FIN_BYTES_RST    = 16'd64;
  localparam logic [15:0] ACK_BYTES_RST    = 16'd64;

  typedef enum logic [1:0] {
    PH_NONE, PH_DATA, PH_FIN, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    K_ACK, K_SYNACK, K_FIN, K_FINACK
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_TIMEOUT, OP_SYNACK, OP_SET_DONE, OP_FIN_PAIR, OP_FINACK, OP_DATA
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_SCAN, ST_FINACK
  } state_t;

  typedef struct packed {
    logic   load;
    logic   clr;
    logic   map_rd;
    logic   map_set;
    logic   scan_start;
    logic   scan_step;
    logic   phase_wr;
    phase_t phase_val;
    logic   emit;
    kind_t  kind;
    logic   last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic scan_done;
    logic clr_done;
  } sts_t;

  // Index of the lowest clear bit; isolate it, then encode with independent ORs.
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] inv;
    logic [WORD_W-1:0] low;
    logic [BIT_W-1:0]  idx;
    inv = ~w;
    low = inv & (~inv + {{(WORD_W-1){1'b0}}, 1'b1});
    idx = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (b[k]) begin
          idx[k] = idx[k] | low[b];
        end
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trae_ctrl.sv =====
// Controller state machine: sequences clearing, lookup, update, scan and replies.
`default_nettype none

module trae_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire trae_pkg::sts_t  sts,
  output trae_pkg::cmd_t       cmd
);

  trae_pkg::state_t state_r;
  trae_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trae_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trae_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_nxt = trae_pkg::ST_IDLE;
      end
      trae_pkg::ST_IDLE: begin
        if (start) state_nxt = trae_pkg::ST_READ;
      end
      trae_pkg::ST_READ: begin
        state_nxt = trae_pkg::ST_DECIDE;
      end
      trae_pkg::ST_DECIDE: begin
        case (sts.op)
          trae_pkg::OP_FIN_PAIR: state_nxt = trae_pkg::ST_FINACK;
          trae_pkg::OP_DATA:     state_nxt = trae_pkg::ST_SCAN;
          default:               state_nxt = trae_pkg::ST_IDLE;
        endcase
      end
      trae_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = trae_pkg::ST_IDLE;
      end
      trae_pkg::ST_FINACK: begin
        state_nxt = trae_pkg::ST_IDLE;
      end
      default: state_nxt = trae_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    cmd.phase_val = trae_pkg::PH_NONE;
    cmd.kind      = trae_pkg::K_ACK;
    busy          = (state_r != trae_pkg::ST_IDLE);
    case (state_r)
      trae_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      trae_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      trae_pkg::ST_READ: begin
        cmd.map_rd = 1'b1;
      end
      trae_pkg::ST_DECIDE: begin
        case (sts.op)
          trae_pkg::OP_TIMEOUT: begin
            cmd.emit = 1'b1;
            cmd.kind = trae_pkg::K_FIN;
            cmd.last = 1'b1;
          end
          trae_pkg::OP_SYNACK: begin
            cmd.phase_wr  = 1'b1;
            cmd.phase_val = trae_pkg::PH_DATA;
            cmd.emit      = 1'b1;
            cmd.kind      = trae_pkg::K_SYNACK;
            cmd.last      = 1'b1;
          end
          trae_pkg::OP_SET_DONE: begin
            cmd.phase_wr  = 1'b1;
            cmd.phase_val = trae_pkg::PH_DONE;
          end
          trae_pkg::OP_FIN_PAIR: begin
            cmd.phase_wr  = 1'b1;
            cmd.phase_val = trae_pkg::PH_FIN;
            cmd.emit      = 1'b1;
            cmd.kind      = trae_pkg::K_FIN;
          end
          trae_pkg::OP_FINACK: begin
            cmd.emit = 1'b1;
            cmd.kind = trae_pkg::K_FINACK;
            cmd.last = 1'b1;
          end
          trae_pkg::OP_DATA: begin
            cmd.map_set    = 1'b1;
            cmd.scan_start = 1'b1;
          end
          default: ;
        endcase
      end
      trae_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.emit = 1'b1;
          cmd.kind = trae_pkg::K_ACK;
          cmd.last = 1'b1;
        end
      end
      trae_pkg::ST_FINACK: begin
        cmd.emit = 1'b1;
        cmd.kind = trae_pkg::K_FINACK;
        cmd.last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/trae_dp.sv =====
// Datapath: input capture, phase and bitmap memories, ack scan, reply registers.
`default_nettype none

module trae_dp #(
  parameter int NUM_FLOWS = trae_pkg::NUM_FLOWS_DEF,
  parameter int SEQ_SPACE = trae_pkg::SEQ_SPACE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire trae_pkg::cmd_t                cmd,
  output trae_pkg::sts_t                     sts,
  input  wire logic                          in_func,
  input  wire logic [trae_pkg::FLOW_W-1:0]   in_flow_index,
  input  wire logic [trae_pkg::NODE_W-1:0]   in_src_node,
  input  wire logic                          in_is_syn,
  input  wire logic                          in_is_fin,
  input  wire logic                          in_is_ack,
  input  wire logic                          in_is_table_update,
  input  wire logic [trae_pkg::SEQ_W-1:0]    in_seq_number,
  input  wire logic [trae_pkg::TIME_W-1:0]   in_stamp,
  input  wire logic [trae_pkg::TIME_W-1:0]   in_now,
  input  wire logic [7:0]                    host_id,
  input  wire logic [15:0]                   resend_delay,
  input  wire logic [15:0]                   syn_bytes,
  input  wire logic [15:0]                   fin_bytes,
  input  wire logic [15:0]                   ack_bytes,
  output logic                               out_strobe,
  output logic [1:0]                         out_kind,
  output logic [trae_pkg::NODE_W-1:0]        out_dest_node,
  output logic [7:0]                         out_src_id,
  output logic [trae_pkg::FLOW_W-1:0]        out_flow_out,
  output logic [trae_pkg::ACKN_W-1:0]        out_ack_number,
  output logic [trae_pkg::SIZE_W-1:0]        out_size_bytes,
  output logic [trae_pkg::TIME_W-1:0]        out_echo_stamp,
  output logic [trae_pkg::TIME_W-1:0]        out_resend_due,
  output logic                               out_resend,
  output logic                               out_last
);

  localparam int WORDS   = (SEQ_SPACE + trae_pkg::WORD_W - 1) / trae_pkg::WORD_W;
  localparam int ENTRIES = NUM_FLOWS * WORDS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW      = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int WW      = $clog2(WORDS + 1);
  localparam int NW      = WW + trae_pkg::BIT_W;

  // Captured transaction
  logic                        func_r;
  logic [trae_pkg::FLOW_W-1:0] flow_r;
  logic [trae_pkg::NODE_W-1:0] src_r;
  logic                        syn_r;
  logic                        fin_r;
  logic                        ack_r;
  logic                        tbl_r;
  logic [trae_pkg::SEQ_W-1:0]  seq_r;
  logic [trae_pkg::TIME_W-1:0] stamp_r;
  logic [trae_pkg::TIME_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      flow_r  <= in_flow_index;
      src_r   <= in_src_node;
      syn_r   <= in_is_syn;
      fin_r   <= in_is_fin;
      ack_r   <= in_is_ack;
      tbl_r   <= in_is_table_update;
      seq_r   <= in_seq_number;
      stamp_r <= in_stamp;
      now_r   <= in_now;
    end
  end

  logic flow_ok;
  logic seq_ok;
  assign flow_ok = (32'(flow_r) < NUM_FLOWS);
  assign seq_ok  = (32'(seq_r) < SEQ_SPACE);

  // Memories
  logic [trae_pkg::WORD_W-1:0] map_mem [ENTRIES];
  trae_pkg::phase_t            phase_mem [NUM_FLOWS];
  logic [trae_pkg::WORD_W-1:0] map_q_r;
  trae_pkg::phase_t            phase_q_r;

  logic [AW-1:0] clr_cnt_r;
  logic [WW-1:0] scan_w_r;
  logic [WW-1:0] chk_w_r;
  logic          chk_v_r;

  logic [AW-1:0] base;
  logic [AW-1:0] seq_addr;
  logic [AW-1:0] scan_addr;
  logic          clr_phase;
  logic [FW-1:0] flow_idx;

  assign base      = AW'(flow_r) * AW'(WORDS);
  assign seq_addr  = base + AW'(seq_r >> trae_pkg::BIT_W);
  assign scan_addr = base + AW'(scan_w_r);
  assign clr_phase = (32'(clr_cnt_r) < NUM_FLOWS);
  assign flow_idx  = FW'(flow_r);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      map_mem[clr_cnt_r] <= '0;
    end else if (cmd.map_set && seq_ok) begin
      map_mem[seq_addr] <= map_q_r |
        ({{(trae_pkg::WORD_W-1){1'b0}}, 1'b1} << seq_r[trae_pkg::BIT_W-1:0]);
    end
    if (cmd.map_rd) begin
      map_q_r <= map_mem[seq_addr];
    end else if (cmd.scan_step && (scan_w_r < WW'(WORDS))) begin
      map_q_r <= map_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr && clr_phase) begin
      phase_mem[clr_cnt_r[FW-1:0]] <= trae_pkg::PH_NONE;
    end else if (cmd.phase_wr && flow_ok) begin
      phase_mem[flow_idx] <= cmd.phase_val;
    end
    if (cmd.map_rd) begin
      phase_q_r <= phase_mem[flow_idx];
    end
  end

  // Clear sweep and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      scan_w_r  <= '0;
      chk_w_r   <= '0;
      chk_v_r   <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.scan_start) begin
        scan_w_r <= '0;
        chk_v_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_w_r < WW'(WORDS)) scan_w_r <= scan_w_r + WW'(1);
        chk_w_r <= scan_w_r;
        chk_v_r <= 1'b1;
      end
    end
  end

  // First missing sequence number from the word under check
  logic                      all_ones;
  logic [trae_pkg::BIT_W-1:0] zidx;
  logic [NW-1:0]             n_pos;
  logic [31:0]               ack_full;
  logic [trae_pkg::ACKN_W-1:0] ack_calc;

  assign all_ones = &map_q_r;
  assign zidx     = trae_pkg::first_zero(map_q_r);
  assign n_pos    = {chk_w_r, zidx};
  assign ack_full = (!all_ones && (32'(n_pos) < SEQ_SPACE)) ? 32'(n_pos) : 32'(SEQ_SPACE);
  assign ack_calc = ack_full[trae_pkg::ACKN_W-1:0];

  // Transaction classification
  trae_pkg::op_t op;
  always_comb begin
    op = trae_pkg::OP_NONE;
    if (!flow_ok) begin
      op = trae_pkg::OP_NONE;
    end else if (func_r) begin
      if (phase_q_r == trae_pkg::PH_DATA || phase_q_r == trae_pkg::PH_FIN)
        op = trae_pkg::OP_TIMEOUT;
    end else if (tbl_r) begin
      op = trae_pkg::OP_NONE;
    end else if (syn_r) begin
      if (!ack_r && phase_q_r == trae_pkg::PH_NONE) op = trae_pkg::OP_SYNACK;
    end else if (fin_r) begin
      if (ack_r)                              op = trae_pkg::OP_SET_DONE;
      else if (phase_q_r == trae_pkg::PH_DATA) op = trae_pkg::OP_FIN_PAIR;
      else                                    op = trae_pkg::OP_FINACK;
    end else if (!ack_r) begin
      op = trae_pkg::OP_DATA;
    end
  end

  assign sts.op        = op;
  assign sts.scan_done = chk_v_r && (!all_ones || chk_w_r == WW'(WORDS - 1));
  assign sts.clr_done  = (clr_cnt_r == AW'(ENTRIES - 1));

  // Saturating timeout time
  logic [trae_pkg::TIME_W:0]   due_sum;
  logic [trae_pkg::TIME_W-1:0] due;
  assign due_sum = {1'b0, now_r} + 33'(resend_delay);
  assign due     = due_sum[trae_pkg::TIME_W] ? '1 : due_sum[trae_pkg::TIME_W-1:0];

  // Reply registers
  logic                        strobe_r;
  trae_pkg::kind_t             kind_r;
  logic [trae_pkg::NODE_W-1:0] dest_r;
  logic [7:0]                  srcid_r;
  logic [trae_pkg::FLOW_W-1:0] flowo_r;
  logic [trae_pkg::ACKN_W-1:0] ackn_r;
  logic [trae_pkg::SIZE_W-1:0] size_r;
  logic [trae_pkg::TIME_W-1:0] echo_r;
  logic [trae_pkg::TIME_W-1:0] rdue_r;
  logic                        resend_r;
  logic                        last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r   <= cmd.kind;
      dest_r   <= src_r;
      srcid_r  <= host_id;
      flowo_r  <= flow_r;
      last_r   <= cmd.last;
      ackn_r   <= '0;
      rdue_r   <= '0;
      resend_r <= 1'b0;
      echo_r   <= stamp_r;
      case (cmd.kind)
        trae_pkg::K_ACK: begin
          ackn_r <= ack_calc;
          size_r <= ack_bytes;
        end
        trae_pkg::K_SYNACK: begin
          size_r <= syn_bytes;
        end
        trae_pkg::K_FIN: begin
          size_r   <= fin_bytes;
          rdue_r   <= due;
          resend_r <= 1'b1;
          echo_r   <= func_r ? stamp_r : now_r;
        end
        default: begin
          size_r <= fin_bytes;
        end
      endcase
    end
  end

  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_dest_node  = dest_r;
  assign out_src_id     = srcid_r;
  assign out_flow_out   = flowo_r;
  assign out_ack_number = ackn_r;
  assign out_size_bytes = size_r;
  assign out_echo_stamp = echo_r;
  assign out_resend_due = rdue_r;
  assign out_resend     = resend_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

// ===== rtl/transport_receiver_ack_engine_top.sv =====
// Top level of the transport receiver ack engine: register file and block wiring.
`default_nettype none

//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-------------------------------
//  input     | start, busy, in_*                      | taken when start & !busy
//  result    | out_strobe, out_*                      | one cycle per result, no stall
//  config    | psel, penable, pwrite, paddr, pwdata,  | write at psel&penable&pwrite,
//            | prdata, pready                         | pready tied high
//
// A transaction goes through capture, memory read and decide once accepted;
// a FIN that opens the fin phase adds a FINACK state for its reply. A data
// transaction adds the bitmap scan: one 64-bit word per cycle out of the single
// read port. Each reply appears on out_* the cycle after it is produced, for
// one cycle; replies of one transaction come back to back, last flags the
// final one. After reset the block sweeps the bitmap and phase memories with
// busy high; register writes still go through. The receiver cannot stall:
// results are never held.

module transport_receiver_ack_engine_top #(
  parameter int NUM_FLOWS = trae_pkg::NUM_FLOWS_DEF,
  parameter int SEQ_SPACE = trae_pkg::SEQ_SPACE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // transaction input
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_func,
  input  wire logic [trae_pkg::FLOW_W-1:0]  in_flow_index,
  input  wire logic [trae_pkg::NODE_W-1:0]  in_src_node,
  input  wire logic                         in_is_syn,
  input  wire logic                         in_is_fin,
  input  wire logic                         in_is_ack,
  input  wire logic                         in_is_table_update,
  input  wire logic [trae_pkg::SEQ_W-1:0]   in_seq_number,
  input  wire logic [trae_pkg::TIME_W-1:0]  in_stamp,
  input  wire logic [trae_pkg::TIME_W-1:0]  in_now,
  // results
  output logic                              out_strobe,
  output logic [1:0]                        out_kind,
  output logic [trae_pkg::NODE_W-1:0]       out_dest_node,
  output logic [7:0]                        out_src_id,
  output logic [trae_pkg::FLOW_W-1:0]       out_flow_out,
  output logic [trae_pkg::ACKN_W-1:0]       out_ack_number,
  output logic [trae_pkg::SIZE_W-1:0]       out_size_bytes,
  output logic [trae_pkg::TIME_W-1:0]       out_echo_stamp,
  output logic [trae_pkg::TIME_W-1:0]       out_resend_due,
  output logic                              out_resend,
  output logic                              out_last,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [trae_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Register file
  logic [7:0]  host_id_r;
  logic [15:0] resend_delay_r;
  logic [15:0] syn_bytes_r;
  logic [15:0] fin_bytes_r;
  logic [15:0] ack_bytes_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[trae_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_id_r      <= trae_pkg::HOST_ID_RST;
      resend_delay_r <= trae_pkg::RESEND_DELAY_RST;
      syn_bytes_r    <= trae_pkg::SYN_BYTES_RST;
      fin_bytes_r    <= trae_pkg::FIN_BYTES_RST;
      ack_bytes_r    <= trae_pkg::ACK_BYTES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        trae_pkg::REG_HOST_ID:      host_id_r      <= pwdata[7:0];
        trae_pkg::REG_RESEND_DELAY: resend_delay_r <= pwdata[15:0];
        trae_pkg::REG_SYN_BYTES:    syn_bytes_r    <= pwdata[15:0];
        trae_pkg::REG_FIN_BYTES:    fin_bytes_r    <= pwdata[15:0];
        trae_pkg::REG_ACK_BYTES:    ack_bytes_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      trae_pkg::REG_HOST_ID:      prdata = 32'(host_id_r);
      trae_pkg::REG_RESEND_DELAY: prdata = 32'(resend_delay_r);
      trae_pkg::REG_SYN_BYTES:    prdata = 32'(syn_bytes_r);
      trae_pkg::REG_FIN_BYTES:    prdata = 32'(fin_bytes_r);
      trae_pkg::REG_ACK_BYTES:    prdata = 32'(ack_bytes_r);
      default:                    prdata = '0;
    endcase
  end

  // Controller / datapath
  trae_pkg::cmd_t cmd;
  trae_pkg::sts_t sts;
  logic           ctrl_busy;

  // start is only looked at in the idle state, where busy is low
  assign busy = ctrl_busy;

  trae_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (ctrl_busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  trae_dp #(
    .NUM_FLOWS (NUM_FLOWS),
    .SEQ_SPACE (SEQ_SPACE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_flow_index      (in_flow_index),
    .in_src_node        (in_src_node),
    .in_is_syn          (in_is_syn),
    .in_is_fin          (in_is_fin),
    .in_is_ack          (in_is_ack),
    .in_is_table_update (in_is_table_update),
    .in_seq_number      (in_seq_number),
    .in_stamp           (in_stamp),
    .in_now             (in_now),
    .host_id            (host_id_r),
    .resend_delay       (resend_delay_r),
    .syn_bytes          (syn_bytes_r),
    .fin_bytes          (fin_bytes_r),
    .ack_bytes          (ack_bytes_r),
    .out_strobe         (out_strobe),
    .out_kind           (out_kind),
    .out_dest_node      (out_dest_node),
    .out_src_id         (out_src_id),
    .out_flow_out       (out_flow_out),
    .out_ack_number     (out_ack_number),
    .out_size_bytes     (out_size_bytes),
    .out_echo_stamp     (out_echo_stamp),
    .out_resend_due     (out_resend_due),
    .out_resend         (out_resend),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
